@@ hdl/utf16d_pkg.sv @@
// Shared types and constants for the UTF-16 stream decoder.
package utf16d_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned UNITS_W = 2;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned HALF_W  = 10;

  localparam logic [CP_W-1:0]    CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0]    SUPP_BASE      = 21'h010000;
  localparam logic [WORD_W-1:0]  SURR_MASK      = 16'hFC00;
  localparam logic [WORD_W-1:0]  SURR_HIGH      = 16'hD800;
  localparam logic [WORD_W-1:0]  SURR_LOW       = 16'hDC00;
  localparam logic [UNITS_W-1:0] UNITS_ONE      = 2'd1;
  localparam logic [UNITS_W-1:0] UNITS_TWO      = 2'd2;

  // One queue entry: a completed word, or a stream end on a half word.
  typedef struct packed {
    logic              half_end;
    logic              last;
    logic [WORD_W-1:0] word;
  } word_entry_t;

endpackage

@@ hdl/utf16_stream_decoder.sv @@
// UTF-16 stream decoder: one byte per cycle unless stalled, one code point per character.
//
// The decoder accepts one byte per clock cycle without pause as long as the
// result side keeps up. A byte that completes a word enters a two-entry word
// queue; the back end then pairs surrogates and loads the output register.
// An output stall fills the queue and then drops s_axis_tready_o. The
// end-of-stream byte (tlast) always yields exactly one result, with tlast set,
// and returns the decoder to the start of a new stream. The byte order register
// may only be changed while no request is in flight.
module utf16_stream_decoder
  import utf16d_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream in.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_stream
  // Code points out.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] code_point, [22:21] units_used, [23] replaced
  output logic        m_axis_tlast_o,   // is_last
  // Configuration: big_endian_order.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic               big_endian_q;
  logic               queue_ready;
  logic               push;
  word_entry_t        push_entry;
  logic               pop;
  logic               entry_valid;
  word_entry_t        entry;
  logic [CP_W-1:0]    code_point;
  logic [UNITS_W-1:0] units_used;
  logic               replaced;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else if (cfg_valid_i) begin
      big_endian_q <= cfg_data_i;
    end
  end

  utf16d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .big_endian_i    (big_endian_q),
    .byte_valid_i    (s_axis_tvalid_i),
    .byte_ready_o    (s_axis_tready_o),
    .data_byte_i     (s_axis_tdata_i),
    .end_of_stream_i (s_axis_tlast_i),
    .queue_ready_i   (queue_ready),
    .push_o          (push),
    .push_entry_o    (push_entry)
  );

  utf16d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (queue_ready),
    .pop_i        (pop),
    .valid_o      (entry_valid),
    .pop_entry_o  (entry)
  );

  utf16d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (entry_valid),
    .entry_i       (entry),
    .pop_o         (pop),
    .res_valid_o   (m_axis_tvalid_o),
    .res_ready_i   (m_axis_tready_i),
    .code_point_o  (code_point),
    .units_used_o  (units_used),
    .replaced_o    (replaced),
    .is_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {replaced, units_used, code_point};

endmodule

@@ hdl/utf16d_front.sv @@
// Front end: takes bytes, pairs them into words in the configured byte order.
module utf16d_front
  import utf16d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        big_endian_i,
  input  logic        byte_valid_i,
  output logic        byte_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  input  logic        queue_ready_i,
  output logic        push_o,
  output word_entry_t push_entry_o
);

  logic       byte_waiting_q, byte_waiting_d;
  logic [7:0] held_byte_q, held_byte_d;
  logic       accept;

  assign byte_ready_o = queue_ready_i;
  assign accept       = byte_valid_i && queue_ready_i;

  always_comb begin
    byte_waiting_d = byte_waiting_q;
    held_byte_d    = held_byte_q;
    push_o         = 1'b0;
    push_entry_o.half_end = !byte_waiting_q;
    push_entry_o.last     = end_of_stream_i;
    push_entry_o.word     = big_endian_i ? {held_byte_q, data_byte_i}
                                         : {data_byte_i, held_byte_q};
    if (accept) begin
      if (byte_waiting_q || end_of_stream_i) begin
        push_o         = 1'b1;
        byte_waiting_d = 1'b0;
      end else begin
        held_byte_d    = data_byte_i;
        byte_waiting_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_waiting_q <= 1'b0;
      held_byte_q    <= '0;
    end else begin
      byte_waiting_q <= byte_waiting_d;
      held_byte_q    <= held_byte_d;
    end
  end

endmodule

@@ hdl/utf16d_fifo.sv @@
// Short word queue between the front end and the surrogate pairing back end.
module utf16d_fifo
  import utf16d_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  word_entry_t push_entry_i,
  output logic        ready_o,
  input  logic        pop_i,
  output logic        valid_o,
  output word_entry_t pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  word_entry_t         slots_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign ready_o     = (count_q != CntW'(Depth));
  assign valid_o     = (count_q != '0);
  assign pop_entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ hdl/utf16d_back.sv @@
// Back end: pairs surrogates, flags malformed input and holds the output register.
module utf16d_back
  import utf16d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               entry_valid_i,
  input  word_entry_t        entry_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [CP_W-1:0]    code_point_o,
  output logic [UNITS_W-1:0] units_used_o,
  output logic               replaced_o,
  output logic               is_last_o
);

  logic               high_waiting_q, high_waiting_d;
  logic [HALF_W-1:0]  high_bits_q, high_bits_d;
  logic               out_valid_q, out_valid_d;
  logic [CP_W-1:0]    cp_q, cp_d;
  logic [UNITS_W-1:0] units_q, units_d;
  logic               repl_q, repl_d;
  logic               last_q, last_d;
  logic               res_valid;
  logic               out_free;
  logic               is_low, is_high;

  assign out_free = !out_valid_q || res_ready_i;
  assign pop_o    = entry_valid_i && out_free;
  assign is_low   = (entry_i.word & SURR_MASK) == SURR_LOW;
  assign is_high  = (entry_i.word & SURR_MASK) == SURR_HIGH;

  always_comb begin
    high_waiting_d = high_waiting_q;
    high_bits_d    = high_bits_q;
    res_valid      = 1'b0;
    cp_d           = CP_REPLACEMENT;
    units_d        = UNITS_ONE;
    repl_d         = 1'b1;
    last_d         = entry_i.last;
    if (pop_o) begin
      if (entry_i.half_end) begin
        // Stream ended on a half word; a pending high surrogate goes with it.
        res_valid      = 1'b1;
        units_d        = high_waiting_q ? UNITS_TWO : UNITS_ONE;
        last_d         = 1'b1;
        high_waiting_d = 1'b0;
      end else if (high_waiting_q) begin
        res_valid      = 1'b1;
        units_d        = UNITS_TWO;
        high_waiting_d = 1'b0;
        if (is_low) begin
          cp_d   = SUPP_BASE + CP_W'({high_bits_q, entry_i.word[HALF_W-1:0]});
          repl_d = 1'b0;
        end
      end else if (is_low) begin
        res_valid = 1'b1;
      end else if (is_high) begin
        if (entry_i.last) begin
          res_valid = 1'b1;
        end else begin
          high_waiting_d = 1'b1;
          high_bits_d    = entry_i.word[HALF_W-1:0];
        end
      end else begin
        res_valid = 1'b1;
        cp_d      = CP_W'(entry_i.word);
        repl_d    = 1'b0;
      end
    end
    out_valid_d = out_free ? res_valid : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_waiting_q <= 1'b0;
      high_bits_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      high_waiting_q <= high_waiting_d;
      high_bits_q    <= high_bits_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      cp_q    <= cp_d;
      units_q <= units_d;
      repl_q  <= repl_d;
      last_q  <= last_d;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign units_used_o = units_q;
  assign replaced_o   = repl_q;
  assign is_last_o    = last_q;

  a_units_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (units_q == UNITS_ONE || units_q == UNITS_TWO))
    else $error("units_used outside one or two");

  a_repl_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && repl_q) |-> (cp_q == CP_REPLACEMENT))
    else $error("replaced result is not U+FFFD");

  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !repl_q && units_q == UNITS_TWO) |-> (cp_q >= SUPP_BASE))
    else $error("surrogate pair decoded below the supplementary planes");

  a_half_end_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.half_end) |=> (out_valid_q && last_q && repl_q))
    else $error("half word at stream end gave no final replacement");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.last) |=> !high_waiting_q)
    else $error("surrogate still held after stream end");

endmodule
